@@ design/gsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, register indexes and helpers for the glyph shelf packer.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int COORD_W = 13;
    localparam int DIM_W   = 10;
    localparam int OFS_W   = 10;
    localparam int FONT_W  = 8;
    localparam int PIDX_W  = 4;
    localparam int CFG_AW  = 2;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    localparam logic [CFG_AW-1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_FONT_SIZE    = 2'd2;

    localparam logic [COORD_W-1:0] RST_ATLAS_WIDTH  = 13'd1024;
    localparam logic [COORD_W-1:0] RST_ATLAS_HEIGHT = 13'd1024;
    localparam logic [FONT_W-1:0]  RST_FONT_SIZE    = 8'd16;

    typedef struct packed {
        logic [COORD_W-1:0] atlas_width;
        logic [COORD_W-1:0] atlas_height;
        logic [FONT_W-1:0]  font_size;
    } t_cfg;

    typedef struct packed {
        logic signed [OFS_W-1:0] bearing_top;
        logic signed [OFS_W-1:0] bearing_left;
        logic [DIM_W-1:0]        glyph_rows;
        logic [DIM_W-1:0]        glyph_width;
    } t_glyph;

    typedef struct packed {
        logic                    atlas_full;
        logic                    new_page;
        logic signed [OFS_W-1:0] offset_y;
        logic signed [OFS_W-1:0] offset_x;
        logic [COORD_W-1:0]      bottom_y;
        logic [COORD_W-1:0]      right_x;
        logic [COORD_W-1:0]      top_y;
        logic [COORD_W-1:0]      left_x;
        logic [PIDX_W-1:0]       page_index;
    } t_result;

    function automatic logic [COORD_W-1:0] sat13(input logic [COORD_W+1:0] v);
        return (v > {2'b00, COORD_MAX}) ? COORD_MAX : v[COORD_W-1:0];
    endfunction

endpackage

@@ design/gsp_place.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_place
// Shelf placement state (cursor, row height, page) and the placement logic.
// ----------------------------------------------------------------------------
module gsp_place #(
    parameter int MAX_PAGES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  gsp_pkg::t_glyph  i_glyph,
    input  gsp_pkg::t_cfg    i_cfg,
    output gsp_pkg::t_result o_result
);
    import gsp_pkg::*;

    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam logic [PW-1:0] LAST_PAGE = PW'(MAX_PAGES - 1);

    logic [COORD_W-1:0] r_cursor_x, n_cursor_x;
    logic [COORD_W-1:0] r_cursor_y, n_cursor_y;
    logic [DIM_W-1:0]   r_row_h,    n_row_h;
    logic [PW-1:0]      r_page,     n_page;

    logic               empty;
    logic [DIM_W-1:0]   cw, ch;
    logic [DIM_W:0]     adv;
    logic [COORD_W:0]   sum_x;
    logic               wrap;
    logic [COORD_W:0]   ny;
    logic [COORD_W+1:0] ny_ch;
    logic               fits;
    logic               at_last;
    logic [COORD_W-1:0] place_x, place_y;
    logic [PW+PIDX_W-1:0] page_ext;

    always_comb begin
        empty = (i_glyph.glyph_width == '0) || (i_glyph.glyph_rows == '0);
        if (empty) begin
            cw  = DIM_W'(i_cfg.font_size >> 1);
            ch  = (i_cfg.font_size != '0) ? DIM_W'(i_cfg.font_size - 8'd1) : '0;
            adv = (DIM_W+1)'(cw);
        end else begin
            cw  = i_glyph.glyph_width;
            ch  = i_glyph.glyph_rows;
            adv = (DIM_W+1)'(i_glyph.glyph_width) + 11'd1;
        end

        sum_x   = {1'b0, r_cursor_x} + (COORD_W+1)'(cw);
        wrap    = sum_x > {1'b0, i_cfg.atlas_width};
        ny      = {1'b0, r_cursor_y} + (COORD_W+1)'(r_row_h) + 14'd1;
        ny_ch   = {1'b0, ny} + (COORD_W+2)'(ch);
        fits    = ny_ch <= {2'b00, i_cfg.atlas_height};
        at_last = (r_page == LAST_PAGE);

        n_page  = r_page;
        place_x = r_cursor_x;
        place_y = r_cursor_y;
        o_result.new_page   = 1'b0;
        o_result.atlas_full = 1'b0;
        if (wrap) begin
            place_x = '0;
            if (fits) begin
                place_y = sat13({1'b0, ny});
            end else begin
                place_y = '0;
                if (at_last) begin
                    o_result.atlas_full = 1'b1;
                end else begin
                    n_page = r_page + PW'(1);
                    o_result.new_page = 1'b1;
                end
            end
        end

        page_ext = {{PIDX_W{1'b0}}, n_page};
        o_result.page_index = page_ext[PIDX_W-1:0];
        o_result.left_x     = place_x;
        o_result.top_y      = place_y;
        o_result.right_x    = sat13((COORD_W+2)'(place_x) + (COORD_W+2)'(cw));
        o_result.bottom_y   = sat13((COORD_W+2)'(place_y) + (COORD_W+2)'(ch));
        o_result.offset_x   = empty ? '0 : i_glyph.bearing_left;
        o_result.offset_y   = empty ? signed'(ch) : i_glyph.bearing_top;

        n_cursor_x = sat13((COORD_W+2)'(place_x) + (COORD_W+2)'(adv));
        n_cursor_y = place_y;
        n_row_h    = (wrap || (ch > r_row_h)) ? ch : r_row_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_row_h    <= '0;
            r_page     <= '0;
        end else if (i_step) begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_row_h    <= n_row_h;
            r_page     <= n_page;
        end
    end

`ifndef SYNTHESIS
    a_page_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.new_page) |=> (r_page == $past(r_page) + PW'(1)))
        else $error("page did not advance on new page");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_cursor_x) && $stable(r_cursor_y)
                     && $stable(r_row_h) && $stable(r_page)))
        else $error("placement state moved without a transfer");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(o_result.new_page && o_result.atlas_full))
        else $error("new page and atlas full together");

    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.atlas_full) |-> (r_page == LAST_PAGE))
        else $error("atlas full below last page");
`endif

endmodule

@@ design/glyph_shelf_packer.sv @@
`timescale 1ns / 1ps
// An input transfer goes through the input reg and then the result reg before
// the earliest result transfer; m_axis_tvalid rises as the result reg loads
// throughput: one glyph per cycle unless the output stalls; cursor state updates
// in the same cycle as the result register load: glyphs never wait on each other
// reset: synchronous active-low i_rst_n clears cursor, row height, page and
// both valid flags; registers return to 1024 x 1024, font size 16
// ----------------------------------------------------------------------------
// glyph_shelf_packer
// Places glyphs into texture atlas pages by shelf packing, stream in and out.
// ----------------------------------------------------------------------------
module glyph_shelf_packer #(
    parameter int MAX_PAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // glyph_width, glyph_rows, bearing_left, bearing_top
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // page_index, left_x, top_y, right_x, bottom_y, offset_x, offset_y, zero pad
    output logic [79:0] m_axis_tdata,
    // new_page, atlas_full
    output logic [1:0]  m_axis_tuser
);
    import gsp_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_glyph  r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result place_res;
    logic    out_free;
    logic    step;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.atlas_width  <= RST_ATLAS_WIDTH;
            r_cfg.atlas_height <= RST_ATLAS_HEIGHT;
            r_cfg.font_size    <= RST_FONT_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ATLAS_WIDTH:  r_cfg.atlas_width  <= i_cfg_wdata;
                REG_ATLAS_HEIGHT: r_cfg.atlas_height <= i_cfg_wdata;
                REG_FONT_SIZE:    r_cfg.font_size    <= i_cfg_wdata[FONT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata;
        end
    end

    gsp_place #(
        .MAX_PAGES (MAX_PAGES)
    ) u_place (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_glyph  (r_in),
        .i_cfg    (r_cfg),
        .o_result (place_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (step) begin
            r_out <= place_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.offset_y, r_out.offset_x, r_out.bottom_y,
                            r_out.right_x, r_out.top_y, r_out.left_x, r_out.page_index};
    assign m_axis_tuser  = {r_out.atlas_full, r_out.new_page};

endmodule

@@ bench/glyph_shelf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_shelf_checker
// Watches the register port and both streams of the glyph shelf packer. Keeps
// its own shelf-packing copy of the atlas cursor, row height, page and layout,
// predicts one placement per accepted glyph and compares each result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_shelf_checker #(
    parameter int MAX_PAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    input  logic        i_glyph_valid,
    input  logic        i_glyph_ready,
    // glyph_width, glyph_rows, bearing_left, bearing_top
    input  logic [39:0] i_glyph_data,
    input  logic        i_place_valid,
    input  logic        i_place_ready,
    // page_index, left_x, top_y, right_x, bottom_y, offset_x, offset_y, zero pad
    input  logic [79:0] i_place_data,
    // new_page, atlas_full
    input  logic [1:0]  i_place_user,
    output int          o_mismatches,
    output int          o_pending
);

    gsp_pkg::t_cfg    layout;
    logic [12:0]      cur_x;
    logic [12:0]      cur_y;
    logic [9:0]       shelf_h;
    logic [3:0]       page;
    gsp_pkg::t_result placements_q[$];
    int               errors = 0;

    function automatic logic [12:0] coord_clip(input int unsigned v);
        return (v > 32'd8191) ? 13'h1fff : v[12:0];
    endfunction

    function automatic gsp_pkg::t_result place_glyph(input gsp_pkg::t_glyph g);
        gsp_pkg::t_result r;
        int unsigned      cell_w;
        int unsigned      cell_h;
        int unsigned      step_w;
        int unsigned      row_y;
        r = '0;
        if (g.glyph_width == 0 || g.glyph_rows == 0) begin
            cell_w = layout.font_size / 2;
            cell_h = (layout.font_size != 0) ? layout.font_size - 1 : 0;
            step_w = cell_w;
            r.offset_x = '0;
            r.offset_y = cell_h[9:0];
        end else begin
            cell_w = g.glyph_width;
            cell_h = g.glyph_rows;
            step_w = cell_w + 1;
            r.offset_x = g.bearing_left;
            r.offset_y = g.bearing_top;
        end
        if (cur_x + cell_w > layout.atlas_width) begin
            row_y = cur_y + shelf_h + 1;
            if (row_y + cell_h > layout.atlas_height) begin
                if (page + 1 < MAX_PAGES) begin
                    page = page + 1;
                    r.new_page = 1'b1;
                end else begin
                    r.atlas_full = 1'b1;
                end
                cur_y = '0;
            end else begin
                cur_y = coord_clip(row_y);
            end
            cur_x = '0;
            shelf_h = '0;
        end
        r.page_index = page;
        r.left_x = cur_x;
        r.top_y = cur_y;
        r.right_x = coord_clip(cur_x + cell_w);
        r.bottom_y = coord_clip(cur_y + cell_h);
        cur_x = coord_clip(cur_x + step_w);
        if (cell_h > shelf_h) begin
            shelf_h = cell_h[9:0];
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0d ns: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        gsp_pkg::t_result want;
        gsp_pkg::t_result seen;
        gsp_pkg::t_glyph  glyph;
        if (!i_rst_n) begin
            layout.atlas_width = gsp_pkg::RST_ATLAS_WIDTH;
            layout.atlas_height = gsp_pkg::RST_ATLAS_HEIGHT;
            layout.font_size = gsp_pkg::RST_FONT_SIZE;
            cur_x = '0;
            cur_y = '0;
            shelf_h = '0;
            page = '0;
            placements_q.delete();
        end else begin
            if (i_place_valid && i_place_ready) begin
                seen = {i_place_user, i_place_data[75:0]};
                if (placements_q.size() == 0) begin
                    $display("%0d ns: placement transfer with none expected, got %h",
                             $time, seen);
                    errors++;
                end else begin
                    want = placements_q.pop_front();
                    check_field("page_index", want.page_index, seen.page_index);
                    check_field("left_x", want.left_x, seen.left_x);
                    check_field("top_y", want.top_y, seen.top_y);
                    check_field("right_x", want.right_x, seen.right_x);
                    check_field("bottom_y", want.bottom_y, seen.bottom_y);
                    check_field("offset_x", 10'(want.offset_x), 10'(seen.offset_x));
                    check_field("offset_y", 10'(want.offset_y), 10'(seen.offset_y));
                    check_field("new_page", want.new_page, seen.new_page);
                    check_field("atlas_full", want.atlas_full, seen.atlas_full);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    gsp_pkg::REG_ATLAS_WIDTH: layout.atlas_width = i_cfg_wdata;
                    gsp_pkg::REG_ATLAS_HEIGHT: layout.atlas_height = i_cfg_wdata;
                    gsp_pkg::REG_FONT_SIZE: layout.font_size = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_glyph_valid && i_glyph_ready) begin
                glyph = i_glyph_data;
                placements_q.insert(placements_q.size(), place_glyph(glyph));
            end
        end
        o_pending <= placements_q.size();
        o_mismatches <= errors;
    end

endmodule

@@ bench/tb_glyph_shelf_packer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_shelf_packer
// Drives glyphs into the shelf packer in random bursts under a changing output
// stall pattern, across several atlas layouts from tiny to oversized, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_glyph_shelf_packer;

    localparam int MAX_PAGES   = 16;
    localparam int CYCLE_LIMIT = 500000;

    typedef enum {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, SQUARE_WAVE} t_stall_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [12:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          mismatches;
    int          pending;

    t_stall_style stall_style = ALWAYS_READY;
    int           style_left = 0;
    int unsigned  tick = 0;
    int           burst_left = 0;

    always #5 i_clk = ~i_clk;

    glyph_shelf_packer #(
        .MAX_PAGES(MAX_PAGES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    glyph_shelf_checker #(
        .MAX_PAGES(MAX_PAGES)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata),
        .i_glyph_valid(s_axis_tvalid),
        .i_glyph_ready(s_axis_tready),
        .i_glyph_data(s_axis_tdata),
        .i_place_valid(m_axis_tvalid),
        .i_place_ready(m_axis_tready),
        .i_place_data(m_axis_tdata),
        .i_place_user(m_axis_tuser),
        .o_mismatches(mismatches),
        .o_pending(pending)
    );

    // output stall pattern, switching style when a random countdown runs out
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style <= t_stall_style'($urandom_range(3));
            style_left <= $urandom_range(20, 300);
        end else begin
            style_left <= style_left - 1;
        end
        case (stall_style)
            ALWAYS_READY: m_axis_tready <= 1'b1;
            COIN_FLIP: m_axis_tready <= ($urandom_range(1) == 1);
            MOSTLY_STALLED: m_axis_tready <= ($urandom_range(3) == 0);
            default: m_axis_tready <= tick[3];
        endcase
        tick <= tick + 1;
    end

    always @(posedge i_clk) begin
        if (tick == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic gsp_pkg::t_glyph make_glyph(input int w, input int h,
                                                   input int bl, input int bt);
        gsp_pkg::t_glyph g;
        g.glyph_width = w[9:0];
        g.glyph_rows = h[9:0];
        g.bearing_left = bl[9:0];
        g.bearing_top = bt[9:0];
        return g;
    endfunction

    // mostly text-sized glyphs, some blanks, a few large ones
    function automatic gsp_pkg::t_glyph random_glyph();
        int unsigned pick;
        int          w;
        int          h;
        pick = $urandom_range(99);
        if (pick < 3) begin
            w = 0;
            h = $urandom_range(1023);
        end else if (pick < 6) begin
            w = $urandom_range(1023);
            h = 0;
        end else if (pick < 84) begin
            w = $urandom_range(1, 48);
            h = $urandom_range(1, 48);
        end else if (pick < 96) begin
            w = $urandom_range(1, 300);
            h = $urandom_range(1, 300);
        end else begin
            w = $urandom_range(1, 1023);
            h = $urandom_range(1, 1023);
        end
        return make_glyph(w, h, $urandom_range(1023), $urandom_range(1023));
    endfunction

    task automatic send_glyph(input gsp_pkg::t_glyph g);
        s_axis_tdata <= g;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 24 : 4)) @(posedge i_clk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 15);
        end
    endtask

    // hold off until every placement is back, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_layout(input logic [12:0] w, input logic [12:0] h,
                              input logic [7:0] f);
        logic [4:0] junk;
        junk = $urandom_range(31);
        cfg_we <= 1'b1;
        cfg_addr <= gsp_pkg::REG_ATLAS_WIDTH;
        cfg_wdata <= w;
        @(posedge i_clk);
        cfg_addr <= gsp_pkg::REG_ATLAS_HEIGHT;
        cfg_wdata <= h;
        @(posedge i_clk);
        cfg_addr <= gsp_pkg::REG_FONT_SIZE;
        cfg_wdata <= {junk, f};
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [12:0] w, input logic [12:0] h,
                             input logic [7:0] f, input int count);
        set_layout(w, h, f);
        repeat (count) send_glyph(random_glyph());
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small page: blanks, row wrap, exact fit, fresh page, oversized glyph
        set_layout(13'd48, 13'd48, 8'd20);
        send_glyph(make_glyph(0, 0, -512, 511));
        send_glyph(make_glyph(10, 0, 0, 0));
        send_glyph(make_glyph(0, 7, 3, -3));
        send_glyph(make_glyph(20, 20, -512, 511));
        send_glyph(make_glyph(1, 1, 511, -512));
        send_glyph(make_glyph(30, 30, -1, 1));
        send_glyph(make_glyph(17, 1, 0, -1));
        send_glyph(make_glyph(1023, 1023, 511, 511));
        send_glyph(make_glyph(0, 0, -512, -512));
        settle();

        run_phase(13'd1024, 13'd1024, 8'd16, 300);
        run_phase(13'd4096, 13'd4096, 8'd255, 300);
        run_phase(13'd8191, 13'd8191, 8'd0, 200);
        run_phase(13'd300, 13'd200, 8'd31, 250);
        run_phase(13'd64, 13'd4096, 8'd1, 200);
        run_phase(13'd4096, 13'd64, 8'd2, 200);
        run_phase(13'd1, 13'd1, 8'd1, 120);
        run_phase(13'd0, 13'd0, 8'd254, 120);

        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/gsp_pkg.sv
design/gsp_place.sv
design/glyph_shelf_packer.sv
bench/glyph_shelf_checker.sv
bench/tb_glyph_shelf_packer.sv
